>>> rtl/running_window_sum_unit_macros.svh
// ----------------------------------------------------------------------------
// running_window_sum_unit_macros
// Assertion macros shared by the running window sum RTL.
// ----------------------------------------------------------------------------
`ifndef RUNNING_WINDOW_SUM_UNIT_MACROS_SVH
`define RUNNING_WINDOW_SUM_UNIT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define RWS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, held off while in reset.
`define RWS_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Types, constants and helpers for the running window sum unit.
// ----------------------------------------------------------------------------
package rws_pkg;

	localparam int WINDOW_MAX_DEF    = 255;
	localparam int HISTORY_DEPTH_DEF = 256;

	localparam int VAL_W  = 32;
	localparam int IDX_W  = 32;
	localparam int WIN_W  = 8;
	localparam int SUM_W  = 48;
	localparam int MISS_W = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN   = 3'd0,
		REG_PER_ITEM     = 3'd1,
		REG_USE_INDEX    = 3'd2,
		REG_DROP_MISSING = 3'd3,
		REG_PAD_START    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_len;
		logic             per_item_window;
		logic             use_index;
		logic             drop_missing;
		logic             pad_start;
	} cfg_t;

	// One ring entry: inclusive prefix sum, missing count and index
	typedef struct packed {
		logic [SUM_W-1:0]  psum;
		logic [MISS_W-1:0] pmiss;
		logic [IDX_W-1:0]  idx;
	} ring_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_FIN
	} state_t;

	// Clamp a raw window length to the largest usable window
	function automatic int clamp_win(logic [WIN_W-1:0] raw, int kmax);
		int r;
		r = int'(raw);
		if (r > kmax) begin
			r = kmax;
		end
		return r;
	endfunction

endpackage

>>> rtl/running_window_sum_unit.sv
// ----------------------------------------------------------------------------
// running_window_sum_unit
// Windowed sum of Q16.16 samples with missing-sample handling.
//
//   channel   handshake            payload
//   in        in_valid/in_ready    value, missing, position_index,
//                                  item_window, start_req
//   out       out_valid/out_ready  window_sum, result_missing
//   cfg       cfg_we               cfg_index, cfg_data
//
// Cumulative mode and zero windows take no ring read; count windows read one
// entry, or none while the series is shorter than the window.
// Index windows probe the ring backward, one entry at a time through
// the single ring read port, m entries back with m up to HISTORY_DEPTH-1.
// Reset clears series state and config; ring contents need no clearing.
// A new beat is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module running_window_sum_unit #(
	parameter int WINDOW_MAX    = rws_pkg::WINDOW_MAX_DEF,
	parameter int HISTORY_DEPTH = rws_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [rws_pkg::VAL_W-1:0]   value,
	input  logic                               missing,
	input  logic [rws_pkg::IDX_W-1:0]          position_index,
	input  logic [rws_pkg::WIN_W-1:0]          item_window,
	input  logic                               start_req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rws_pkg::SUM_W-1:0]   window_sum,
	output logic                               result_missing,
	input  logic                               cfg_we,
	input  logic [rws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rws_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int A_W = $clog2(HISTORY_DEPTH);

	rws_pkg::cfg_t        cfg;
	logic                 ring_we, ring_re;
	logic [A_W-1:0]       ring_waddr, ring_raddr;
	rws_pkg::ring_entry_t ring_wdata, ring_rdata;

	rws_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rws_ring #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	rws_core #(
		.WINDOW_MAX    (WINDOW_MAX),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.value          (value),
		.missing        (missing),
		.position_index (position_index),
		.item_window    (item_window),
		.start_req      (start_req),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.window_sum     (window_sum),
		.result_missing (result_missing),
		.ring_we        (ring_we),
		.ring_waddr     (ring_waddr),
		.ring_wdata     (ring_wdata),
		.ring_re        (ring_re),
		.ring_raddr     (ring_raddr),
		.ring_rdata     (ring_rdata)
	);

endmodule

>>> rtl/rws_cfg.sv
// ----------------------------------------------------------------------------
// rws_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module rws_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rws_pkg::CFG_DATA_W-1:0]   cfg_data,
	output rws_pkg::cfg_t                    cfg
);

	rws_pkg::cfg_t cfg_q;

	// Register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len      <= '0;
			cfg_q.per_item_window <= 1'b0;
			cfg_q.use_index       <= 1'b0;
			cfg_q.drop_missing    <= 1'b1;
			cfg_q.pad_start       <= 1'b0;
		end else if (cfg_we) begin
			case (rws_pkg::cfg_reg_t'(cfg_index))
				rws_pkg::REG_WINDOW_LEN:   cfg_q.window_len      <= cfg_data;
				rws_pkg::REG_PER_ITEM:     cfg_q.per_item_window <= cfg_data[0];
				rws_pkg::REG_USE_INDEX:    cfg_q.use_index       <= cfg_data[0];
				rws_pkg::REG_DROP_MISSING: cfg_q.drop_missing    <= cfg_data[0];
				rws_pkg::REG_PAD_START:    cfg_q.pad_start       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/rws_ring.sv
// ----------------------------------------------------------------------------
// rws_ring
// History ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rws_ring #(
	parameter int HISTORY_DEPTH = rws_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]   waddr,
	input  rws_pkg::ring_entry_t               wdata,
	input  logic                               re,
	input  logic [$clog2(HISTORY_DEPTH)-1:0]   raddr,
	output rws_pkg::ring_entry_t               rdata
);

	rws_pkg::ring_entry_t mem [HISTORY_DEPTH];
	rws_pkg::ring_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rws_core.sv
// ----------------------------------------------------------------------------
// rws_core
// Series state, ring sequencing, base search and result register.
// ----------------------------------------------------------------------------
`include "running_window_sum_unit_macros.svh"

module rws_core #(
	parameter int WINDOW_MAX    = rws_pkg::WINDOW_MAX_DEF,
	parameter int HISTORY_DEPTH = rws_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rws_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [rws_pkg::VAL_W-1:0]   value,
	input  logic                               missing,
	input  logic [rws_pkg::IDX_W-1:0]          position_index,
	input  logic [rws_pkg::WIN_W-1:0]          item_window,
	input  logic                               start_req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [rws_pkg::SUM_W-1:0]   window_sum,
	output logic                               result_missing,
	output logic                               ring_we,
	output logic [$clog2(HISTORY_DEPTH)-1:0]   ring_waddr,
	output rws_pkg::ring_entry_t               ring_wdata,
	output logic                               ring_re,
	output logic [$clog2(HISTORY_DEPTH)-1:0]   ring_raddr,
	input  rws_pkg::ring_entry_t               ring_rdata
);

	localparam int KMAX  = (WINDOW_MAX < HISTORY_DEPTH - 1) ? WINDOW_MAX : HISTORY_DEPTH - 1;
	localparam int K_W   = $clog2(KMAX + 1);
	localparam int A_W   = $clog2(HISTORY_DEPTH);
	localparam int A1_W  = A_W + 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SW    = rws_pkg::SUM_W;
	localparam int MW    = rws_pkg::MISS_W;

	rws_pkg::state_t state_q, state_d;

	// Series state
	logic [CNT_W-1:0]          items_q;
	logic [SW-1:0]             rp_q;
	logic [MW-1:0]             rm_q;
	logic signed [SW-1:0]      cum_q;
	logic                      seen_p_q, seen_a_q;
	logic [A_W-1:0]            wr_slot_q;
	logic [rws_pkg::WIN_W-1:0] first_win_q;

	// Per-beat work registers
	logic [A_W-1:0]            cur_slot_q;
	logic [CNT_W-1:0]          pos_q;
	logic [K_W-1:0]            k_q;
	logic [A_W-1:0]            lim_q, m_q;
	logic [rws_pkg::IDX_W-1:0] idx_in_q;
	logic                      cum_mode_q, idx_mode_q, pre_miss_q;
	logic [SW-1:0]             base_sum_q;
	logic [MW-1:0]             base_miss_q;

	// Result register
	logic                      out_valid_q, out_miss_q;
	logic [SW-1:0]             out_sum_q;

	logic                      accept, load_out, hit, at_lim;
	logic [CNT_W-1:0]          is0;
	logic [SW-1:0]             rp0, rp_new;
	logic [MW-1:0]             rm0, rm_new;
	logic signed [SW-1:0]      cum0, cum_new;
	logic signed [SW:0]        cum_ext;
	logic                      seen_p_new, seen_a_new;
	logic [rws_pkg::WIN_W-1:0] first_new;
	logic [K_W-1:0]            k_new, pad_k;
	logic                      pad_hit, cum_mode;
	logic [A_W-1:0]            lim_new;
	logic [SW-1:0]             win_sum;
	logic [MW-1:0]             mcnt;
	logic                      win_miss, res_miss;

	assign accept = in_valid && in_ready;

	// Series values seen by the incoming beat, cleared on a new series
	always_comb begin
		is0        = start_req ? '0 : items_q;
		rp0        = start_req ? '0 : rp_q;
		rm0        = start_req ? '0 : rm_q;
		cum0       = start_req ? '0 : cum_q;
		seen_p_new = (start_req ? 1'b0 : seen_p_q) || !missing;
		seen_a_new = (start_req ? 1'b0 : seen_a_q) || missing;
		first_new  = (is0 == '0) ? item_window : first_win_q;
		cum_ext    = {cum0[SW-1], cum0} + (SW+1)'(value);
		if (missing) begin
			rp_new  = rp0;
			rm_new  = rm0 + MW'(1);
			cum_new = cum0;
		end else begin
			rp_new = rp0 + SW'(value);
			rm_new = rm0;
			if (cum_ext[SW] != cum_ext[SW-1]) begin
				cum_new = cum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			end else begin
				cum_new = cum_ext[SW-1:0];
			end
		end
		k_new    = K_W'(rws_pkg::clamp_win(cfg.per_item_window ? item_window : cfg.window_len,
			KMAX));
		pad_k    = K_W'(rws_pkg::clamp_win(cfg.per_item_window ? first_new : cfg.window_len,
			KMAX));
		pad_hit  = cfg.pad_start && (pad_k != '0) && (int'(is0) + 1 < int'(pad_k));
		cum_mode = !cfg.per_item_window && (cfg.window_len == '0);
		lim_new  = (int'(is0) < HISTORY_DEPTH - 1) ? A_W'(is0) : A_W'(HISTORY_DEPTH - 1);
	end

	// Ring write of the new prefix entry
	assign ring_we         = accept;
	assign ring_waddr      = wr_slot_q;
	assign ring_wdata.psum  = rp_new;
	assign ring_wdata.pmiss = rm_new;
	assign ring_wdata.idx   = position_index;

	// Entry m places back from the current one
	assign ring_raddr = (cur_slot_q >= m_q) ? (cur_slot_q - m_q)
		: A_W'(A1_W'(cur_slot_q) + A1_W'(HISTORY_DEPTH) - A1_W'(m_q));

	assign hit    = !idx_mode_q || ((idx_in_q - ring_rdata.idx) >= rws_pkg::IDX_W'(k_q));
	assign at_lim = (m_q == lim_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rws_pkg::ST_IDLE: begin
				if (accept) begin
					if (cum_mode || k_new == '0) begin
						state_d = rws_pkg::ST_FIN;
					end else if (cfg.use_index) begin
						state_d = (is0 == '0) ? rws_pkg::ST_FIN : rws_pkg::ST_RD;
					end else begin
						state_d = (int'(is0) >= int'(k_new)) ? rws_pkg::ST_RD
							: rws_pkg::ST_FIN;
					end
				end
			end
			rws_pkg::ST_RD:  state_d = rws_pkg::ST_CHK;
			rws_pkg::ST_CHK: state_d = (hit || at_lim) ? rws_pkg::ST_FIN : rws_pkg::ST_RD;
			rws_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = rws_pkg::ST_IDLE;
				end
			end
			default: state_d = rws_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		ring_re  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			rws_pkg::ST_IDLE: in_ready = 1'b1;
			rws_pkg::ST_RD:   ring_re  = 1'b1;
			rws_pkg::ST_CHK:  ;
			rws_pkg::ST_FIN:  load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Result from the base entry
	always_comb begin
		win_sum  = rp_q - base_sum_q;
		mcnt     = rm_q - base_miss_q;
		win_miss = (k_q == '0) || (mcnt == MW'(k_q)) || (!cfg.drop_missing && mcnt != '0);
		if (cum_mode_q) begin
			res_miss = pre_miss_q || (!cfg.drop_missing && seen_a_q);
		end else begin
			res_miss = pre_miss_q || win_miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rws_pkg::ST_IDLE;
			items_q     <= '0;
			rp_q        <= '0;
			rm_q        <= '0;
			cum_q       <= '0;
			seen_p_q    <= 1'b0;
			seen_a_q    <= 1'b0;
			wr_slot_q   <= '0;
			first_win_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				items_q     <= (int'(is0) < HISTORY_DEPTH) ? is0 + CNT_W'(1) : is0;
				rp_q        <= rp_new;
				rm_q        <= rm_new;
				cum_q       <= cum_new;
				seen_p_q    <= seen_p_new;
				seen_a_q    <= seen_a_new;
				first_win_q <= first_new;
				wr_slot_q   <= (wr_slot_q == A_W'(HISTORY_DEPTH - 1)) ? '0
					: wr_slot_q + A_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-beat working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_slot_q  <= wr_slot_q;
			pos_q       <= is0;
			k_q         <= k_new;
			lim_q       <= lim_new;
			m_q         <= cfg.use_index ? A_W'(1) : A_W'(k_new);
			idx_in_q    <= position_index;
			cum_mode_q  <= cum_mode;
			idx_mode_q  <= cfg.use_index;
			pre_miss_q  <= !seen_p_new || pad_hit;
			base_sum_q  <= '0;
			base_miss_q <= '0;
		end
		if (state_q == rws_pkg::ST_CHK) begin
			if (hit || (pos_q == CNT_W'(HISTORY_DEPTH))) begin
				base_sum_q  <= ring_rdata.psum;
				base_miss_q <= ring_rdata.pmiss;
			end
			if (!hit && !at_lim) begin
				m_q <= m_q + A_W'(1);
			end
		end
		if (load_out) begin
			out_miss_q <= res_miss;
			out_sum_q  <= res_miss ? '0 : (cum_mode_q ? cum_q : win_sum);
		end
	end

	assign out_valid      = out_valid_q;
	assign window_sum     = out_sum_q;
	assign result_missing = out_miss_q;

	// Checks
	`RWS_ASSERT_IMP(a_no_self_read, clk, arst_n, ring_re, ring_raddr != cur_slot_q, "read of the entry just written")
	`RWS_ASSERT_IMP(a_search_bound, clk, arst_n, state_q == rws_pkg::ST_CHK && idx_mode_q, m_q <= lim_q && m_q != '0, "search beyond history")
	`RWS_ASSERT_IMP(a_out_hold, clk, arst_n, load_out, !out_valid_q || out_ready, "result overwritten")
	`RWS_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid_q && out_miss_q, out_sum_q == '0, "missing result with non-zero sum")

endmodule
